/* design/phcp_pkg.sv */
package phcp_pkg;

  localparam int MAX_WORDS_DEF = 512;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CMP_W         = 20;

  localparam logic [15:0] HDR_LEARNED = 16'h0000;
  localparam logic [15:0] HDR_SHORT_A = 16'h5000;
  localparam logic [15:0] HDR_SHORT_B = 16'h6000;
  localparam logic [15:0] BURST_MAX   = 16'd255;
  localparam logic [16:0] SUM_MAX     = 17'd200;
  localparam int          SHORT_DIGITS = 24;
  localparam logic [CMP_W-1:0] COUNT_BASE = 20'd16;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BAD_CHAR = 3'd2;
  localparam logic [2:0] ST_FORMAT   = 3'd3;
  localparam logic [2:0] ST_SHORT    = 3'd4;
  localparam logic [2:0] ST_TOO_LONG = 3'd5;
  localparam logic [2:0] ST_COUNT    = 3'd6;

  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] word_value;
    logic [8:0]  word_index;
    logic [10:0] byte_length;
    logic [2:0]  status;
    logic        last_of_code;
  } result_t;

  typedef struct packed {
    logic word_push;
    logic status_push;
  } push_t;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

/* design/pronto_hex_code_parser_top.sv */
// Pronto hex code parser.
// Input channel (char_valid/char_ready): one text character per word in
// symbol, with has_char marking a real character and end_of_text closing
// the code. Output channel (res_valid/res_ready): a parsed 16-bit word
// (item_kind 0, word_value, word_index) for every fourth hex digit, and a
// final status (item_kind 1, byte_length, status, last_of_code) for the
// end word. One input word yields zero, one or two results; a word result
// comes before the status of the same input word.
// Each result is registered in the queue before it is offered.
// Throughput: one input word per cycle, limited only by the output port,
// which moves one result per cycle; results sit in a four-entry queue and
// char_ready drops while fewer than two entries are free.
// Reset clears the parse state and empties the queue. When the receiver
// stalls, results hold in the queue and input is stopped as room runs out.
module pronto_hex_code_parser_top #(
  parameter int MAX_WORDS = phcp_pkg::MAX_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  symbol,
  input  logic        has_char,
  input  logic        end_of_text,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        item_kind,
  output logic [15:0] word_value,
  output logic [8:0]  word_index,
  output logic [10:0] byte_length,
  output logic [2:0]  status,
  output logic        last_of_code
);

  phcp_pkg::push_t   push;
  phcp_pkg::result_t word_ent, status_ent, head;
  logic              room;
  logic              take;

  assign char_ready = room;
  assign take       = char_valid && char_ready;

  phcp_parser #(
    .MAX_WORDS(MAX_WORDS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .symbol     (symbol),
    .has_char   (has_char),
    .end_of_text(end_of_text),
    .push       (push),
    .word_ent   (word_ent),
    .status_ent (status_ent)
  );

  phcp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .word_ent  (word_ent),
    .status_ent(status_ent),
    .room      (room),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .head      (head)
  );

  assign item_kind    = head.item_kind;
  assign word_value   = head.word_value;
  assign word_index   = head.word_index;
  assign byte_length  = head.byte_length;
  assign status       = head.status;
  assign last_of_code = head.last_of_code;

endmodule

/* design/phcp_parser.sv */
module phcp_parser #(
  parameter int MAX_WORDS = phcp_pkg::MAX_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        symbol,
  input  logic              has_char,
  input  logic              end_of_text,
  output phcp_pkg::push_t   push,
  output phcp_pkg::result_t word_ent,
  output phcp_pkg::result_t status_ent
);

  localparam int DC_W  = $clog2(4 * MAX_WORDS + 1);
  localparam int IDX_W = DC_W - 2;
  localparam logic [DC_W-1:0] DC_LIMIT = DC_W'(4 * MAX_WORDS);

  logic [15:0]     acc, acc_next, acc_upd, acc_shift;
  logic [DC_W-1:0] dc, dc_next, dc_upd;
  logic [15:0]     hdr, hdr_next, hdr_upd;
  logic [15:0]     len_a, len_a_next, len_a_upd;
  logic [15:0]     len_b, len_b_next, len_b_upd;
  logic            aborted, aborted_next, aborted_upd;
  logic            overflow, overflow_next, overflow_upd;

  logic            active;
  logic [4:0]      dig;
  logic [IDX_W-1:0] idx;
  logic [16:0]     sum;
  logic [2:0]      st;
  logic [DC_W-1:0] half;
  logic            hdr_short;

  assign dig    = phcp_pkg::hex_digit(symbol);
  assign active = has_char && !aborted && !overflow &&
                  symbol != phcp_pkg::CHAR_SPACE && symbol != phcp_pkg::CHAR_TAB;
  assign idx       = dc[DC_W-1:2];
  assign acc_shift = {acc[11:0], dig[3:0]};

  always_comb begin
    acc_upd      = acc;
    dc_upd       = dc;
    hdr_upd      = hdr;
    len_a_upd    = len_a;
    len_b_upd    = len_b;
    aborted_upd  = aborted;
    overflow_upd = overflow;
    push.word_push   = 1'b0;
    push.status_push = take && end_of_text;
    word_ent = '0;
    word_ent.item_kind  = phcp_pkg::KIND_WORD;
    word_ent.word_value = acc_shift;
    word_ent.word_index = 9'(idx);
    if (take && active) begin
      if (!dig[4]) begin
        aborted_upd = 1'b1;
      end else if (dc >= DC_LIMIT) begin
        overflow_upd = 1'b1;
      end else begin
        dc_upd = dc + 1'b1;
        if (dc[1:0] == 2'b11) begin
          push.word_push = 1'b1;
          acc_upd = '0;
          if (idx == IDX_W'(0)) hdr_upd = acc_shift;
          if (idx == IDX_W'(2)) len_a_upd = acc_shift;
          if (idx == IDX_W'(3)) len_b_upd = acc_shift;
        end else begin
          acc_upd = acc_shift;
        end
      end
    end
  end

  assign sum       = {1'b0, len_a_upd} + {1'b0, len_b_upd};
  assign hdr_short = hdr_upd == phcp_pkg::HDR_SHORT_A || hdr_upd == phcp_pkg::HDR_SHORT_B;
  assign half      = dc_upd >> 1;

  always_comb begin
    if (aborted_upd) begin
      st = phcp_pkg::ST_BAD_CHAR;
    end else if (overflow_upd) begin
      st = phcp_pkg::ST_COUNT;
    end else if (dc_upd == '0) begin
      st = phcp_pkg::ST_EMPTY;
    end else if (dc_upd[1:0] != 2'b00 ||
                 (hdr_upd != phcp_pkg::HDR_LEARNED && !hdr_short)) begin
      st = phcp_pkg::ST_FORMAT;
    end else if (hdr_short) begin
      st = (dc_upd == DC_W'(phcp_pkg::SHORT_DIGITS)) ? phcp_pkg::ST_OK : phcp_pkg::ST_SHORT;
    end else if (len_a_upd > phcp_pkg::BURST_MAX || len_b_upd > phcp_pkg::BURST_MAX ||
                 sum > phcp_pkg::SUM_MAX) begin
      st = phcp_pkg::ST_TOO_LONG;
    end else if (phcp_pkg::CMP_W'(dc_upd) != {sum, 3'b000} + phcp_pkg::COUNT_BASE) begin
      st = phcp_pkg::ST_COUNT;
    end else begin
      st = phcp_pkg::ST_OK;
    end
  end

  always_comb begin
    status_ent = '0;
    status_ent.item_kind    = phcp_pkg::KIND_STATUS;
    status_ent.status       = st;
    status_ent.last_of_code = 1'b1;
    status_ent.byte_length  = (st == phcp_pkg::ST_OK) ? 11'(half) : 11'd0;
  end

  always_comb begin
    if (take && end_of_text) begin
      acc_next      = '0;
      dc_next       = '0;
      hdr_next      = '0;
      len_a_next    = '0;
      len_b_next    = '0;
      aborted_next  = 1'b0;
      overflow_next = 1'b0;
    end else begin
      acc_next      = acc_upd;
      dc_next       = dc_upd;
      hdr_next      = hdr_upd;
      len_a_next    = len_a_upd;
      len_b_next    = len_b_upd;
      aborted_next  = aborted_upd;
      overflow_next = overflow_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      dc       <= '0;
      hdr      <= '0;
      len_a    <= '0;
      len_b    <= '0;
      aborted  <= 1'b0;
      overflow <= 1'b0;
    end else begin
      acc      <= acc_next;
      dc       <= dc_next;
      hdr      <= hdr_next;
      len_a    <= len_a_next;
      len_b    <= len_b_next;
      aborted  <= aborted_next;
      overflow <= overflow_next;
    end
  end

`ifndef ASSERT_OFF
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && end_of_text |=> dc == '0 && !aborted && !overflow && acc == '0)
    else $error("parser state not cleared after end of text");
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    dc <= DC_LIMIT)
    else $error("digit count past limit");
`endif

endmodule

/* design/phcp_out_queue.sv */
module phcp_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  phcp_pkg::push_t   push,
  input  phcp_pkg::result_t word_ent,
  input  phcp_pkg::result_t status_ent,
  output logic              room,
  output logic              res_valid,
  input  logic              res_ready,
  output phcp_pkg::result_t head
);

  localparam int DEPTH = phcp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  phcp_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next, st_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;
  logic [1:0]       n_push;

  assign pop       = res_valid && res_ready;
  assign res_valid = count != '0;
  assign room      = count <= CNT_W'(DEPTH - 2);
  assign head      = mem[rd_ptr];
  assign n_push    = {1'b0, push.word_push} + {1'b0, push.status_push};
  assign st_ptr    = push.word_push ? wr_ptr + 1'b1 : wr_ptr;

  always_comb begin
    wr_ptr_next = wr_ptr + PTR_W'(n_push);
    rd_ptr_next = pop ? rd_ptr + 1'b1 : rd_ptr;
    count_next  = count + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.word_push) mem[wr_ptr] <= word_ent;
    if (push.status_push) mem[st_ptr] <= status_ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue overrun");
  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (push.word_push || push.status_push) |-> room)
    else $error("word pushed without room");
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && n_push == 2'd0 |=> count == $past(count) - 1'b1)
    else $error("queue count lost a pop");
`endif

endmodule

/* tb/sv/testbench.sv */
module testbench;

  localparam int WORD_LIMIT  = phcp_pkg::MAX_WORDS_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int NROWS       = 25;
  localparam int PHASE_ITEMS = 200;

  typedef enum int {
    FLAW_BURST,
    FLAW_SUM,
    FLAW_COUNT,
    FLAW_MANGLE,
    FLAW_NONE
  } flaw_t;

  typedef struct packed {
    logic [7:0]  sym;
    logic        hc;
    logic        eot;
    logic        typed;
    logic [2:0]  st;
    logic [10:0] len;
  } drow_t;

  logic        clk;
  logic        rst;
  logic        char_valid;
  logic        char_ready;
  logic [7:0]  symbol;
  logic        has_char;
  logic        end_of_text;
  logic        res_valid;
  logic        res_ready;
  logic        item_kind;
  logic [15:0] word_value;
  logic [8:0]  word_index;
  logic [10:0] byte_length;
  logic [2:0]  status;
  logic        last_of_code;

  pronto_hex_code_parser_top dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .symbol       (symbol),
    .has_char     (has_char),
    .end_of_text  (end_of_text),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .item_kind    (item_kind),
    .word_value   (word_value),
    .word_index   (word_index),
    .byte_length  (byte_length),
    .status       (status),
    .last_of_code (last_of_code)
  );

  // parser state as seen by the predictor
  logic [15:0] acc_word;
  logic [11:0] digits_seen;
  logic [15:0] header_seen;
  logic [15:0] burst_one;
  logic [15:0] burst_two;
  logic        abort_seen;
  logic        overflow_seen;

  phcp_pkg::result_t pending_results[$];
  logic [7:0]  text_q[$];
  drow_t       directed_rows [NROWS];
  int          consumed;
  int          mismatches;
  int          quiet;
  int          send_idle_pct;
  int          stall_pct;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(1) ? phcp_pkg::CHAR_SPACE : phcp_pkg::CHAR_TAB;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (nibble_of(c) >= 0 || c == phcp_pkg::CHAR_SPACE || c == phcp_pkg::CHAR_TAB);
    return c;
  endfunction

  task automatic clear_parse();
    acc_word      = '0;
    digits_seen   = '0;
    header_seen   = '0;
    burst_one     = '0;
    burst_two     = '0;
    abort_seen    = 1'b0;
    overflow_seen = 1'b0;
  endtask

  function automatic logic [2:0] code_verdict();
    int total;
    total = int'(burst_one) + int'(burst_two);
    if (abort_seen) return phcp_pkg::ST_BAD_CHAR;
    if (overflow_seen) return phcp_pkg::ST_COUNT;
    if (digits_seen == '0) return phcp_pkg::ST_EMPTY;
    if (digits_seen[1:0] != 2'd0 ||
        (header_seen != phcp_pkg::HDR_LEARNED && header_seen != phcp_pkg::HDR_SHORT_A &&
         header_seen != phcp_pkg::HDR_SHORT_B))
      return phcp_pkg::ST_FORMAT;
    if (header_seen == phcp_pkg::HDR_SHORT_A || header_seen == phcp_pkg::HDR_SHORT_B)
      return (int'(digits_seen) == phcp_pkg::SHORT_DIGITS) ? phcp_pkg::ST_OK
                                                           : phcp_pkg::ST_SHORT;
    if (burst_one > phcp_pkg::BURST_MAX || burst_two > phcp_pkg::BURST_MAX ||
        total > int'(phcp_pkg::SUM_MAX))
      return phcp_pkg::ST_TOO_LONG;
    if (int'(digits_seen) != total * 8 + int'(phcp_pkg::COUNT_BASE)) return phcp_pkg::ST_COUNT;
    return phcp_pkg::ST_OK;
  endfunction

  task automatic parse_char(input logic [7:0] s, input logic hc, input logic eot);
    int                nib;
    logic [11:0]       slot;
    phcp_pkg::result_t r;
    if (hc && !abort_seen && !overflow_seen &&
        s != phcp_pkg::CHAR_SPACE && s != phcp_pkg::CHAR_TAB) begin
      nib = nibble_of(s);
      if (nib < 0) begin
        abort_seen = 1'b1;
      end else if (int'(digits_seen) >= 4 * WORD_LIMIT) begin
        overflow_seen = 1'b1;
      end else begin
        acc_word = {acc_word[11:0], 4'(nib)};
        digits_seen++;
        if (digits_seen[1:0] == 2'd0) begin
          slot = (digits_seen >> 2) - 12'd1;
          case (slot)
            12'd0: header_seen = acc_word;
            12'd2: burst_one = acc_word;
            12'd3: burst_two = acc_word;
            default: ;
          endcase
          r = '0;
          r.item_kind  = phcp_pkg::KIND_WORD;
          r.word_value = acc_word;
          r.word_index = slot[8:0];
          pending_results.push_back(r);
          acc_word = '0;
        end
      end
    end
    if (eot) begin
      r = '0;
      r.item_kind    = phcp_pkg::KIND_STATUS;
      r.status       = code_verdict();
      r.byte_length  = (r.status == phcp_pkg::ST_OK) ? 11'(digits_seen >> 1) : 11'd0;
      r.last_of_code = 1'b1;
      pending_results.push_back(r);
      clear_parse();
    end
  endtask

  task automatic send(input logic [7:0] s, input logic hc, input logic eot);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid  <= 1'b1;
    symbol      <= s;
    has_char    <= hc;
    end_of_text <= eot;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    consumed++;
    parse_char(s, hc, eot);
  endtask

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 40) $display("ERROR: %s", what);
  endtask

  task automatic put_digit(input logic [3:0] n);
    text_q.push_back(hex_char(n));
    if ($urandom_range(15) == 0) text_q.push_back(blank_char());
  endtask

  task automatic put_word(input logic [15:0] w);
    for (int i = 3; i >= 0; i--) put_digit(w[i*4 +: 4]);
  endtask

  task automatic mangle();
    int pos;
    pos = (text_q.size() == 0) ? 0 : $urandom_range(text_q.size() - 1);
    case ($urandom_range(2))
      0: text_q.insert(pos, junk_char());
      1: if (text_q.size() != 0) text_q.delete(pos);
      default: put_digit(4'($urandom_range(15)));
    endcase
  endtask

  // send the text built so far, then close the code
  task automatic emit_code();
    int   mode;
    logic tail;
    mode = $urandom_range(9);
    for (int i = 0; i < text_q.size(); i++) begin
      tail = (i == text_q.size() - 1) && mode < 4;
      if ($urandom_range(31) == 0) send(8'($urandom_range(255)), 1'b0, 1'b0);
      send(text_q[i], 1'b1, tail);
    end
    if (mode == 9) send(junk_char(), 1'b1, 1'b1);
    else if (mode >= 4 || text_q.size() == 0) send(8'($urandom_range(255)), 1'b0, 1'b1);
    text_q.delete();
  endtask

  task automatic learned_code(input int a, input int b, input flaw_t flaw);
    int pairs;
    pairs = a + b;
    case (flaw)
      FLAW_BURST: a = $urandom_range(256, 65535);
      FLAW_SUM:   b = 201 - a + $urandom_range(0, 54);
      FLAW_COUNT: pairs = pairs + $urandom_range(1, 2);
      default: ;
    endcase
    put_word(phcp_pkg::HDR_LEARNED);
    put_word(16'($urandom));
    put_word(16'(a));
    put_word(16'(b));
    repeat (2 * pairs) put_word(16'($urandom));
    if (flaw == FLAW_MANGLE) mangle();
    emit_code();
  endtask

  task automatic random_code();
    int   pick;
    int   a;
    pick = $urandom_range(99);
    if (pick < 30) begin
      put_word($urandom_range(1) ? phcp_pkg::HDR_SHORT_A : phcp_pkg::HDR_SHORT_B);
      repeat (5) put_word(16'($urandom));
      if ($urandom_range(4) == 0) mangle();
      emit_code();
    end else if (pick < 62) begin
      a = $urandom_range(0, 4);
      pick = $urandom_range(7);
      learned_code(a, $urandom_range(0, 4 - a), (pick > 4) ? FLAW_NONE : flaw_t'(pick));
    end else if (pick < 78) begin
      case ($urandom_range(3))
        0: put_word(phcp_pkg::HDR_LEARNED);
        1: put_word(phcp_pkg::HDR_SHORT_A);
        2: put_word(phcp_pkg::HDR_SHORT_B);
        default: put_word(16'($urandom));
      endcase
      repeat ($urandom_range(0, 6)) put_word(16'($urandom));
      repeat ($urandom_range(0, 3)) put_digit(4'($urandom_range(15)));
      emit_code();
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 8))
        text_q.push_back($urandom_range(1) ? hex_char(4'($urandom_range(15)))
                                           : 8'($urandom_range(255)));
      emit_code();
    end else begin
      repeat ($urandom_range(0, 3)) text_q.push_back(blank_char());
      emit_code();
    end
  endtask

  always @(negedge clk) res_ready <= !rst && ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : check_port
    phcp_pkg::result_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d value %h index %0d status %0d",
                         item_kind, word_value, word_index, status));
      end else begin
        want = pending_results.pop_front();
        if (item_kind !== want.item_kind || word_value !== want.word_value ||
            word_index !== want.word_index || byte_length !== want.byte_length ||
            status !== want.status || last_of_code !== want.last_of_code)
          report({$sformatf("got k%0d v%h i%0d len%0d st%0d l%0d",
                            item_kind, word_value, word_index, byte_length, status,
                            last_of_code),
                  $sformatf(", want k%0d v%h i%0d len%0d st%0d l%0d",
                            want.item_kind, want.word_value, want.word_index,
                            want.byte_length, want.status, want.last_of_code)});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (res_valid && res_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int                target;
    int                idle_of [4];
    int                stall_of [4];
    phcp_pkg::result_t typed;
    idle_of  = '{0, 46, 0, 17};
    stall_of = '{0, 0, 46, 17};
    rst           = 1'b1;
    char_valid    = 1'b0;
    symbol        = '0;
    has_char      = 1'b0;
    end_of_text   = 1'b0;
    res_ready     = 1'b0;
    consumed      = 0;
    mismatches    = 0;
    quiet         = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    clear_parse();
    directed_rows = '{
      '{8'h00,                1'b0, 1'b1, 1'b1, phcp_pkg::ST_EMPTY,    11'd0},
      '{8'h47,                1'b1, 1'b1, 1'b1, phcp_pkg::ST_BAD_CHAR, 11'd0},
      '{8'hFF,                1'b1, 1'b1, 1'b1, phcp_pkg::ST_BAD_CHAR, 11'd0},
      '{8'h00,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h37,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h00,                1'b0, 1'b1, 1'b1, phcp_pkg::ST_BAD_CHAR, 11'd0},
      '{phcp_pkg::CHAR_SPACE, 1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{phcp_pkg::CHAR_TAB,   1'b1, 1'b1, 1'b1, phcp_pkg::ST_EMPTY,    11'd0},
      '{8'h66,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h46,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h30,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h61,                1'b1, 1'b1, 1'b1, phcp_pkg::ST_FORMAT,   11'd0},
      '{8'h30,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h30,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h30,                1'b1, 1'b1, 1'b1, phcp_pkg::ST_FORMAT,   11'd0},
      '{8'h36,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h30,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h30,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h30,                1'b1, 1'b1, 1'b1, phcp_pkg::ST_SHORT,    11'd0},
      '{8'h35,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h30,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'hAA,                1'b0, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h30,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h30,                1'b1, 1'b0, 1'b0, phcp_pkg::ST_OK,       11'd0},
      '{8'h39,                1'b1, 1'b1, 1'b1, phcp_pkg::ST_FORMAT,   11'd0}
    };
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NROWS; i++) begin
      send(directed_rows[i].sym, directed_rows[i].hc, directed_rows[i].eot);
      if (directed_rows[i].typed) begin
        typed = '0;
        typed.item_kind    = phcp_pkg::KIND_STATUS;
        typed.status       = directed_rows[i].st;
        typed.byte_length  = directed_rows[i].len;
        typed.last_of_code = 1'b1;
        pending_results[pending_results.size() - 1] = typed;
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_of[ph];
      stall_pct     = stall_of[ph];
      target = consumed + PHASE_ITEMS;
      while (consumed < target) random_code();
      if (ph == 0) begin
        // run past the word limit
        put_word(phcp_pkg::HDR_LEARNED);
        repeat (WORD_LIMIT + 1) put_word(16'($urandom));
        emit_code();
      end
      if (ph == 1) begin
        // hold the burst sum at its limit with an empty body
        put_word(phcp_pkg::HDR_LEARNED);
        put_word(16'($urandom));
        put_word(16'd120);
        put_word(16'd80);
        emit_code();
      end
    end

    @(negedge clk);
    char_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
design/phcp_pkg.sv
design/phcp_parser.sv
design/phcp_out_queue.sv
design/pronto_hex_code_parser_top.sv
tb/sv/testbench.sv
